[hw/rtl/dap_pkg.sv]
// Shared types, constants and functions of the detector antenna pattern unit.
// Holds the fixed-point formats, the CORDIC arctangent table and the product term list.
// Depends on nothing.
package dap_pkg;

  localparam int FXB         = 28;
  localparam int FX_W        = 36;
  localparam int TURN_BITS   = 48;
  localparam int MAX_STEPS   = 40;
  localparam int CX_W        = 44;
  localparam int CZ_W        = 49;
  localparam int CX_TO_FX    = 12;
  localparam int OUT_W       = 25;
  localparam int NUM_RES     = 10;
  localparam int NUM_TERMS   = 26;
  localparam int NUM_SUMS    = 6;
  localparam int NUM_LANES   = 9;
  localparam int REG_W       = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int TIME_W      = 32;
  localparam int PAT_LAT     = 7;

  typedef logic signed [FX_W-1:0] fx_t;
  typedef logic [TURN_BITS-1:0]   angle_t;

  localparam fx_t FX_THREE = fx_t'(3) <<< FXB;
  localparam logic signed [2*FX_W-1:0] MUL_RND = (2*FX_W)'(1) << (FXB - 1);
  localparam logic signed [CX_W-1:0] CX_RND = CX_W'(1) << (CX_TO_FX - 1);
  localparam logic signed [CX_W-1:0] CORDIC_X0 = CX_W'(64'h9B74EDA8) << 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOUR_OFFSET, REG_ARM_ORIENT, REG_LATITUDE, REG_DECLINATION,
    REG_ARM_OPENING, REG_POLARIZATION, REG_ROT_RATE
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_CA, OP_SA, OP_C2A, OP_S2A, OP_C2G, OP_S2G, OP_CL, OP_SL, OP_C2L, OP_S2L,
    OP_CD, OP_SD, OP_C2D, OP_S2D, OP_SZ, OP_C2P, OP_S2P, OP_L3, OP_D3
  } op_t;

  localparam int NUM_OPS = 19;

  typedef fx_t opv_t [NUM_OPS];

  typedef enum logic [2:0] {SC_1, SC_2, SC_4, SC_8, SC_16, SC_34, SC_32} scale_t;

  typedef struct packed {
    op_t    a;
    op_t    b;
    op_t    c;
    op_t    d;
    op_t    e;
    logic   five;
    scale_t sc;
  } term_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
    logic [1:0]             quad;
  } cord_t;

  localparam term_t TERMS [NUM_TERMS] = '{
    '{OP_S2G, OP_L3,  OP_D3,  OP_C2A, OP_CA, 1'b0, SC_16},
    '{OP_C2G, OP_SL,  OP_D3,  OP_S2A, OP_CA, 1'b0, SC_4},
    '{OP_S2G, OP_S2L, OP_S2D, OP_CA,  OP_CA, 1'b0, SC_4},
    '{OP_C2G, OP_CL,  OP_S2D, OP_SA,  OP_CA, 1'b0, SC_2},
    '{OP_S2G, OP_CL,  OP_CL,  OP_CD,  OP_CD, 1'b1, SC_34},
    '{OP_C2G, OP_SL,  OP_SD,  OP_C2A, OP_CA, 1'b0, SC_1},
    '{OP_S2G, OP_L3,  OP_SD,  OP_S2A, OP_CA, 1'b0, SC_4},
    '{OP_C2G, OP_CL,  OP_CD,  OP_CA,  OP_CA, 1'b0, SC_1},
    '{OP_S2G, OP_S2L, OP_CD,  OP_SA,  OP_CA, 1'b0, SC_2},
    '{OP_S2G, OP_S2D, OP_S2L, OP_SA,  OP_CA, 1'b0, SC_4},
    '{OP_C2G, OP_S2D, OP_CL,  OP_CA,  OP_CA, 1'b0, SC_2},
    '{OP_C2G, OP_D3,  OP_SL,  OP_C2A, OP_CA, 1'b0, SC_2},
    '{OP_S2G, OP_D3,  OP_L3,  OP_S2A, OP_CA, 1'b0, SC_8},
    '{OP_C2G, OP_C2D, OP_CL,  OP_SA,  OP_CA, 1'b0, SC_1},
    '{OP_S2G, OP_S2D, OP_L3,  OP_C2A, OP_CA, 1'b0, SC_8},
    '{OP_S2G, OP_C2D, OP_S2L, OP_CA,  OP_CA, 1'b0, SC_2},
    '{OP_C2G, OP_S2D, OP_SL,  OP_S2A, OP_CA, 1'b0, SC_2},
    '{OP_S2G, OP_SD,  OP_CD,  OP_CL,  OP_CL, 1'b1, SC_32},
    '{OP_S2G, OP_SD,  OP_L3,  OP_C2A, OP_CA, 1'b0, SC_2},
    '{OP_C2G, OP_SD,  OP_SL,  OP_S2A, OP_CA, 1'b0, SC_1},
    '{OP_S2G, OP_CD,  OP_S2L, OP_CA,  OP_CA, 1'b0, SC_2},
    '{OP_C2G, OP_CD,  OP_CL,  OP_SA,  OP_CA, 1'b0, SC_1},
    '{OP_S2G, OP_SD,  OP_S2L, OP_SA,  OP_CA, 1'b0, SC_2},
    '{OP_C2G, OP_SD,  OP_CL,  OP_CA,  OP_CA, 1'b0, SC_1},
    '{OP_C2G, OP_CD,  OP_SL,  OP_C2A, OP_CA, 1'b0, SC_1},
    '{OP_S2G, OP_CD,  OP_L3,  OP_S2A, OP_CA, 1'b0, SC_4}
  };

  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic signed [2*FX_W-1:0] p;
    p = a * b;
    p = p + MUL_RND;
    return fx_t'(p >>> FXB);
  endfunction

  function automatic fx_t fx_scale(fx_t v, scale_t sc);
    logic signed [FX_W+1:0] e;
    logic signed [FX_W+1:0] w;
    e = v;
    case (sc)
      SC_1:    w = e;
      SC_2:    w = (e + 1) >>> 1;
      SC_4:    w = (e + 2) >>> 2;
      SC_8:    w = (e + 4) >>> 3;
      SC_16:   w = (e + 8) >>> 4;
      SC_34:   w = (3 * e + 2) >>> 2;
      SC_32:   w = (3 * e + 1) >>> 1;
      default: w = e;
    endcase
    return fx_t'(w);
  endfunction

  // Shift-and-subtract division, used only while the constant table is built.
  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 1/n in Q60 by its power series.
  function automatic logic [63:0] atan_inv(logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] t;
    p = udiv(64'd1 << 60, n);
    sum = '0;
    k = '0;
    while (p != 64'd0) begin
      t = udiv(p, 2 * k + 1);
      sum = k[0] ? sum - t : sum + t;
      p = udiv(udiv(p, n), n);
      k = k + 1;
    end
    return sum;
  endfunction

  typedef angle_t atan_tab_t [MAX_STEPS];

  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    logic [63:0] pi_q;
    logic [63:0] d;
    logic [63:0] r;
    logic [63:0] q;
    pi_q = 4 * (4 * atan_inv(64'd5) - atan_inv(64'd239));
    d = 2 * pi_q;
    for (int i = 0; i < MAX_STEPS; i++) begin
      r = (i == 0) ? (pi_q >> 2) : atan_inv(64'd1 << i);
      q = '0;
      for (int b = 0; b < TURN_BITS; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
      end
      tab[i] = q[TURN_BITS-1:0];
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

[hw/rtl/dap_cordic_cell.sv]
// One CORDIC rotation step, registered.
// Uses the arctangent table and the iteration record of dap_pkg.
module dap_cordic_cell import dap_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  ce,
  input  cord_t cin,
  output cord_t cout
);

  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;
  logic signed [CZ_W-1:0] at;
  cord_t                  cnext;

  always_comb begin
    dx = cin.y >>> STEP;
    dy = cin.x >>> STEP;
    at = $signed({1'b0, ATAN_TAB[STEP]});
    cnext.quad = cin.quad;
    if (cin.z[CZ_W-1]) begin
      cnext.x = cin.x + dx;
      cnext.y = cin.y - dy;
      cnext.z = cin.z + at;
    end else begin
      cnext.x = cin.x - dx;
      cnext.y = cin.y + dy;
      cnext.z = cin.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cout <= cnext;
    end
  end

endmodule

[hw/rtl/dap_cordic.sv]
// Sine and cosine of a turn-fraction angle by a chain of CORDIC cells.
// Uses dap_cordic_cell and dap_pkg; the cell outputs and the quadrant-corrected result are registered.
module dap_cordic import dap_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic   clk,
  input  logic   ce,
  input  angle_t angle,
  output fx_t    cos_out,
  output fx_t    sin_out
);

  cord_t chain [STEPS+1];
  fx_t   cq;
  fx_t   sq;
  fx_t   c_next;
  fx_t   s_next;

  always_comb begin
    chain[0].x = CORDIC_X0;
    chain[0].y = '0;
    chain[0].z = CZ_W'(angle[TURN_BITS-3:0]);
    chain[0].quad = angle[TURN_BITS-1:TURN_BITS-2];
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    dap_cordic_cell #(.STEP(i)) u_cell (
      .clk  (clk),
      .ce   (ce),
      .cin  (chain[i]),
      .cout (chain[i+1])
    );
  end

  always_comb begin
    cq = fx_t'((chain[STEPS].x + CX_RND) >>> CX_TO_FX);
    sq = fx_t'((chain[STEPS].y + CX_RND) >>> CX_TO_FX);
    case (chain[STEPS].quad)
      2'd0: begin
        c_next = cq;
        s_next = sq;
      end
      2'd1: begin
        c_next = -sq;
        s_next = cq;
      end
      2'd2: begin
        c_next = -cq;
        s_next = -sq;
      end
      default: begin
        c_next = sq;
        s_next = -cq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_out <= c_next;
      sin_out <= s_next;
    end
  end

endmodule

[hw/rtl/dap_pattern.sv]
// Product tree that turns the trigonometric values into the ten pattern results.
// Uses the term list and fixed-point helpers of dap_pkg; seven register stages.
module dap_pattern import dap_pkg::*; #(
  parameter int OUT_FRAC_BITS = 20
) (
  input  logic             clk,
  input  logic             ce,
  input  opv_t             ops,
  output logic [OUT_W-1:0] res [NUM_RES],
  output logic             sat
);

  localparam int SH  = OUT_FRAC_BITS - FXB;
  localparam int LSH = (SH > 24) ? 24 : ((SH > 0) ? SH : 0);
  localparam int RSH = (SH < 0) ? -SH : 0;
  localparam int WW  = FX_W + 25;
  localparam logic signed [WW-1:0] RND     = (WW'(1) << RSH) >> 1;
  localparam logic signed [WW-1:0] OUT_MAX = (WW'(1) << (OUT_W - 1)) - WW'(1);
  localparam logic signed [WW-1:0] OUT_MIN = -(WW'(1) << (OUT_W - 1));

  opv_t opd [1:PAT_LAT-1];
  fx_t  r1 [NUM_TERMS];
  fx_t  r2 [NUM_TERMS];
  fx_t  r3 [NUM_TERMS];
  fx_t  r4 [NUM_TERMS];
  fx_t  g  [NUM_SUMS];
  fx_t  f  [NUM_SUMS];
  fx_t  q  [3][4];
  fx_t  fo [2];
  fx_t  rv [NUM_RES];

  always_ff @(posedge clk) begin
    if (ce) begin
      opd[1] <= ops;
      for (int k = 2; k < PAT_LAT; k++) begin
        opd[k] <= opd[k-1];
      end
    end
  end

  for (genvar t = 0; t < NUM_TERMS; t++) begin : g_term
    localparam term_t TM = TERMS[t];
    always_ff @(posedge clk) begin
      if (ce) begin
        r1[t] <= fx_mul(ops[TM.a], ops[TM.b]);
        r2[t] <= fx_mul(r1[t], opd[1][TM.c]);
        r3[t] <= fx_mul(r2[t], opd[2][TM.d]);
        r4[t] <= TM.five ? fx_scale(fx_mul(r3[t], opd[3][TM.e]), TM.sc)
                         : fx_scale(r3[t], TM.sc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      g[0] <= r4[0] - r4[1] + r4[2] - r4[3] + r4[4];
      g[1] <= r4[5] + r4[6] + r4[7] + r4[8];
      g[2] <= -r4[9] - r4[10] - r4[11] - r4[12];
      g[3] <= r4[18] - (r4[19] <<< 1) + r4[20] - r4[21];
      g[4] <= -r4[13] + r4[14] + r4[15] - r4[16] - r4[17];
      g[5] <= -r4[22] - r4[23] + r4[24] + r4[25];
      for (int k = 0; k < NUM_SUMS; k++) begin
        f[k] <= fx_mul(opd[5][OP_SZ], g[k]);
      end
      for (int k = 0; k < 3; k++) begin
        q[k][0] <= fx_mul(f[2*k], opd[6][OP_C2P]);
        q[k][1] <= fx_mul(f[2*k+1], opd[6][OP_S2P]);
        q[k][2] <= fx_mul(f[2*k+1], opd[6][OP_C2P]);
        q[k][3] <= fx_mul(f[2*k], opd[6][OP_S2P]);
      end
      fo[0] <= f[0];
      fo[1] <= f[1];
    end
  end

  always_comb begin
    logic signed [WW-1:0] w;
    rv[0] = fo[0];
    rv[1] = fo[1];
    rv[2] = q[0][0] + q[0][1];
    rv[3] = q[0][2] - q[0][3];
    rv[4] = rv[3] <<< 1;
    rv[5] = -(rv[2] <<< 1);
    rv[6] = q[1][0] + q[1][1];
    rv[7] = q[1][2] - q[1][3];
    rv[8] = q[2][0] + q[2][1];
    rv[9] = q[2][2] - q[2][3];
    sat = 1'b0;
    for (int j = 0; j < NUM_RES; j++) begin
      w = rv[j];
      w = ((w <<< LSH) + RND) >>> RSH;
      if (w > OUT_MAX) begin
        sat = 1'b1;
        res[j] = OUT_W'(OUT_MAX);
      end else if (w < OUT_MIN) begin
        sat = 1'b1;
        res[j] = OUT_W'(OUT_MIN);
      end else begin
        res[j] = OUT_W'(w);
      end
    end
  end

endmodule

[hw/rtl/detector_antenna_pattern_unit.sv]
// Top level of the detector antenna pattern unit: configuration registers,
// hour-angle stages, nine CORDIC chains and the pattern product tree.
// Depends on dap_pkg, dap_cordic and dap_pattern.
//
// The unit takes one time sample per clock unless stalled and returns, for each, the plus
// and cross antenna patterns, the patterns rotated by the polarization angle and their
// derivatives, in signed Q4.OUT_FRAC_BITS with a flag for saturation. A sample passes
// the hour-angle multiply and angle registers, the CORDIC cells and their rounding stage,
// the product tree and an output register. The pipeline stalls as a whole only when a
// result waits at the output and the last stage holds another one. Configuration is
// written by the user only while no item is in flight; the unit does not enforce it.
module detector_antenna_pattern_unit import dap_pkg::*; #(
  parameter int CORDIC_STEPS  = 24,
  parameter int OUT_FRAC_BITS = 20,
  parameter int ANGLE_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // time_ticks [31:0]
  input  logic [TIME_W-1:0]    s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // f_plus, f_cross, rot_plus, rot_cross, rot_plus_d_pol, rot_cross_d_pol,
  // rot_plus_d_ra, rot_cross_d_ra, rot_plus_d_dec, rot_cross_d_dec, 25 bits each
  output logic [255:0]         m_tdata,
  // saturated
  output logic                 m_tuser
);

  localparam int LAT      = CORDIC_STEPS + 3 + PAT_LAT;
  localparam int DROP_RAW = TURN_BITS - ANGLE_BITS;
  localparam int DROP     = (DROP_RAW < 0) ? 0 : ((DROP_RAW > 32) ? 32 : DROP_RAW);
  localparam angle_t ANG_MASK = ~((angle_t'(1) << DROP) - angle_t'(1));

  logic [31:0]        hour_offset;
  logic [31:0]        arm_orient;
  logic [31:0]        latitude;
  logic [31:0]        declination;
  logic [31:0]        arm_opening;
  logic [31:0]        polarization;
  logic [REG_W-1:0]   rot_rate;

  logic               ce;
  logic               out_load;
  logic [LAT-1:0]     vld;
  logic [TURN_BITS-1:0] t_ext;
  logic [47:0]        p00;
  logic [23:0]        p10;
  logic [23:0]        p01;
  logic [23:0]        psum;
  angle_t             prod;
  angle_t             ha;
  angle_t             g_ang;
  angle_t             lam;
  angle_t             del;
  angle_t             psi;
  angle_t             ang_next [NUM_LANES];
  angle_t             ang [NUM_LANES];
  fx_t                cv [NUM_LANES];
  fx_t                sv [NUM_LANES];
  opv_t               ops;
  logic [OUT_W-1:0]   res [NUM_RES];
  logic               sat;
  logic [255:0]       data_next;

  function automatic angle_t dbl(angle_t a);
    return {a[TURN_BITS-2:0], 1'b0} & ANG_MASK;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_offset  <= '0;
      arm_orient   <= '0;
      latitude     <= '0;
      declination  <= '0;
      arm_opening  <= '0;
      polarization <= '0;
      rot_rate     <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_HOUR_OFFSET:  hour_offset  <= cfg_data[31:0];
        REG_ARM_ORIENT:   arm_orient   <= cfg_data[31:0];
        REG_LATITUDE:     latitude     <= cfg_data[31:0];
        REG_DECLINATION:  declination  <= cfg_data[31:0];
        REG_ARM_OPENING:  arm_opening  <= cfg_data[31:0];
        REG_POLARIZATION: polarization <= cfg_data[31:0];
        REG_ROT_RATE:     rot_rate     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ce       = m_tready || !m_tvalid || !vld[LAT-1];
  assign out_load = ce && (m_tready || !m_tvalid);
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // The rate times the time, modulo one turn, from three 24-bit partial products.
  assign t_ext = {{(TURN_BITS-TIME_W){s_tdata[TIME_W-1]}}, s_tdata};

  always_ff @(posedge clk) begin
    if (ce) begin
      p00 <= rot_rate[23:0] * t_ext[23:0];
      p10 <= 24'(rot_rate[47:24] * t_ext[23:0]);
      p01 <= 24'(rot_rate[23:0] * t_ext[47:24]);
    end
  end

  always_comb begin
    psum  = p10 + p01;
    prod  = p00 + {psum, 24'b0};
    ha    = ({hour_offset, 16'b0} - prod) & ANG_MASK;
    g_ang = {arm_orient, 16'b0} & ANG_MASK;
    lam   = {latitude, 16'b0} & ANG_MASK;
    del   = {declination, 16'b0} & ANG_MASK;
    psi   = {polarization, 16'b0} & ANG_MASK;
    ang_next[0] = ha;
    ang_next[1] = dbl(ha);
    ang_next[2] = dbl(g_ang);
    ang_next[3] = lam;
    ang_next[4] = dbl(lam);
    ang_next[5] = del;
    ang_next[6] = dbl(del);
    ang_next[7] = {arm_opening, 16'b0} & ANG_MASK;
    ang_next[8] = dbl(psi);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ang <= ang_next;
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    dap_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clk     (clk),
      .ce      (ce),
      .angle   (ang[k]),
      .cos_out (cv[k]),
      .sin_out (sv[k])
    );
  end

  always_comb begin
    ops[OP_CA]  = cv[0];
    ops[OP_SA]  = sv[0];
    ops[OP_C2A] = cv[1];
    ops[OP_S2A] = sv[1];
    ops[OP_C2G] = cv[2];
    ops[OP_S2G] = sv[2];
    ops[OP_CL]  = cv[3];
    ops[OP_SL]  = sv[3];
    ops[OP_C2L] = cv[4];
    ops[OP_S2L] = sv[4];
    ops[OP_CD]  = cv[5];
    ops[OP_SD]  = sv[5];
    ops[OP_C2D] = cv[6];
    ops[OP_S2D] = sv[6];
    ops[OP_SZ]  = sv[7] | (cv[7] & '0);
    ops[OP_C2P] = cv[8];
    ops[OP_S2P] = sv[8];
    ops[OP_L3]  = FX_THREE - cv[4];
    ops[OP_D3]  = FX_THREE - cv[6];
  end

  dap_pattern #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_pattern (
    .clk (clk),
    .ce  (ce),
    .ops (ops),
    .res (res),
    .sat (sat)
  );

  always_comb begin
    data_next = '0;
    for (int j = 0; j < NUM_RES; j++) begin
      data_next[j*OUT_W +: OUT_W] = res[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= data_next;
      m_tuser <= sat;
    end
  end

endmodule
